// ===== hdl/dfa_tfm_pkg.sv =====
// dfa_tfm_pkg: types, constants and state codes for the table-filling dfa minimizer
// no dependencies
package dfa_tfm_pkg;
	localparam int MAX_STATES  = 16;
	localparam int MAX_SYMBOLS = 4;
	localparam int SW = 4;
	localparam int KW = 2;
	localparam int NSLOT = MAX_STATES + 1;

	localparam logic [1:0] MODE_TRANS  = 2'd0;
	localparam logic [1:0] MODE_FINAL  = 2'd1;
	localparam logic [1:0] MODE_RUN    = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] REG_NUM_STATES  = 2'd0;
	localparam logic [1:0] REG_NUM_SYMBOLS = 2'd1;
	localparam logic [1:0] REG_START       = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] src_state;
		logic [1:0] symbol;
		logic [3:0] dst_state;
		logic       final_flag;
	} in_beat_t;

	typedef struct packed {
		logic [3:0] state_index;
		logic [3:0] class_rep;
		logic       is_accepting;
		logic       in_start_class;
		logic       useless;
		logic       last;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PROW,
		ST_PSYM,
		ST_PCHK,
		ST_PEND,
		ST_OROW,
		ST_ORWAIT,
		ST_RSYM,
		ST_RCHK,
		ST_REND,
		ST_EMIT
	} fsm_t;
endpackage

// ===== hdl/dfa_table_filling_minimizer_core.sv =====
// dfa_table_filling_minimizer_core: loads a dfa, runs table-filling minimization, emits classes
// depends on dfa_tfm_pkg
//
//  channel | signals                          | handshake
//  --------+----------------------------------+-----------------------------------
//  input   | start, busy, in_beat              | beat taken when start && !busy
//  result  | out_valid, out_beat               | one-cycle strobe per beat, no back-pressure
//  config  | psel penable pwrite paddr pwdata  | apb write, pready tied high
//
// a load is taken while busy is low and leaves busy low; a run raises busy from the next cycle.
// run (n states, m symbols after clamping): an init phase, then marking passes repeated
// until a pass marks nothing new. output: one beat per state, plus for a non-final state
// reachability sweeps until a sweep adds nothing. reset clears registers and final flags only.
// results cannot be stalled: each beat is shown for exactly one cycle.
module dfa_table_filling_minimizer_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  dfa_tfm_pkg::in_beat_t  in_beat,
	output logic                   out_valid,
	output dfa_tfm_pkg::out_beat_t out_beat,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import dfa_tfm_pkg::*;

	// config registers
	logic [4:0] num_states_q;
	logic [2:0] num_symbols_q;
	logic [3:0] start_state_q;
	logic [1:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q  <= 5'd1;
			num_symbols_q <= 3'd1;
			start_state_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NUM_STATES:  num_states_q  <= pwdata[4:0];
				REG_NUM_SYMBOLS: num_symbols_q <= pwdata[2:0];
				REG_START:       start_state_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_NUM_STATES:  prdata[4:0] = num_states_q;
			REG_NUM_SYMBOLS: prdata[2:0] = num_symbols_q;
			REG_START:       prdata[3:0] = start_state_q;
			default: ;
		endcase
	end

	// clamped counts, taken at run start
	logic [4:0] n_q;
	logic [2:0] m_q;
	logic [4:0] n_clamp;
	logic [2:0] m_clamp;
	always_comb begin
		n_clamp = (num_states_q == 5'd0) ? 5'd1 : num_states_q;
		m_clamp = (num_symbols_q == 3'd0) ? 3'd1
			: ((num_symbols_q > 3'(MAX_SYMBOLS)) ? 3'(MAX_SYMBOLS) : num_symbols_q);
	end

	// final flags in flops, all zero after reset
	logic [NSLOT-1:0] fin_q;

	// transition memory
	logic [SW-1:0] trans_mem [MAX_STATES*MAX_SYMBOLS];
	logic [SW+KW-1:0] tr_addr;
	logic [SW-1:0]    tr_rdata;
	// distinct matrix memory, one row of NSLOT bits per state slot
	logic [NSLOT-1:0] dm_mem [NSLOT];
	logic [4:0]       dm_raddr;
	logic [NSLOT-1:0] dm_rdata;
	logic             dm_we;
	logic [4:0]       dm_waddr;
	logic [NSLOT-1:0] dm_wdata;

	logic accept;
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept && in_beat.mode == MODE_TRANS)
			trans_mem[{in_beat.src_state, in_beat.symbol}] <= in_beat.dst_state;
		tr_rdata <= trans_mem[tr_addr];
	end

	always_ff @(posedge clk) begin
		if (dm_we)
			dm_mem[dm_waddr] <= dm_wdata;
		dm_rdata <= dm_mem[dm_raddr];
	end

	// sequencer state
	fsm_t       st_q, st_d;
	logic [4:0] i_q;      // current row
	logic [2:0] k_q;      // current symbol
	logic [1:0] ph_q;     // sub-step within a symbol
	logic [4:0] si_q;     // successor of i on k
	logic [NSLOT-1:0] row_q;   // row being updated
	logic [4:0] sj_q [NSLOT];  // successor of each j for current k
	logic [4:0] jj_q;     // column sweep for successor table
	logic       changed_q;
	logic [NSLOT-1:0] seen_q;
	logic       grew_q;
	logic [4:0] ri_q;     // reachability sweep row

	// successor clamp
	function automatic logic [4:0] clamp_succ(input logic [3:0] t, input logic [4:0] n);
		clamp_succ = ({1'b0, t} >= n) ? n : {1'b0, t};
	endfunction

	assign busy = (st_q != ST_IDLE);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (accept && in_beat.mode == MODE_RUN) st_d = ST_INIT;
			ST_INIT:   if (i_q == n_q) st_d = ST_PROW;
			ST_PROW:   st_d = ST_PSYM;
			ST_PSYM:   if (ph_q == 2'd3 && jj_q == n_q) st_d = ST_PCHK;
			ST_PCHK:   st_d = (k_q + 3'd1 == m_q) ? ST_PEND : ST_PSYM;
			ST_PEND:   if (i_q == n_q) st_d = changed_q ? ST_PROW : ST_OROW;
				else st_d = ST_PROW;
			ST_OROW:   st_d = ST_ORWAIT;
			ST_ORWAIT: st_d = fin_q[i_q] ? ST_EMIT : ST_RSYM;
			ST_RSYM:   if (ph_q == 2'd2) st_d = ST_RCHK;
			ST_RCHK:   if (k_q + 3'd1 == m_q) st_d = ST_REND; else st_d = ST_RSYM;
			ST_REND:   if (ri_q + 5'd1 >= n_q && !grew_q && !seen_q[ri_q]) st_d = ST_EMIT;
				else if (ri_q + 5'd1 >= n_q && !grew_q) st_d = ST_EMIT;
				else st_d = ST_RSYM;
			ST_EMIT:   st_d = (i_q + 5'd1 == n_q) ? ST_IDLE : ST_OROW;
			default:   st_d = ST_IDLE;
		endcase
	end

	// datapath
	logic [NSLOT-1:0] fin_mask;
	logic [NSLOT-1:0] init_row;
	logic [NSLOT-1:0] newrow;
	logic [4:0] tsucc;
	logic       hit;
	always_comb begin
		// finality only counts below n, the sink and stale flags read as rejecting
		for (int j = 0; j < NSLOT; j++)
			fin_mask[j] = fin_q[j] && (5'(j) < n_q);
		init_row = '0;
		for (int j = 0; j < NSLOT; j++)
			if (5'(j) <= n_q) init_row[j] = fin_mask[i_q] != fin_mask[j];
		tsucc = clamp_succ(tr_rdata, n_q);
		newrow = row_q;
		for (int j = 0; j < NSLOT; j++)
			if (5'(j) <= n_q && dm_rdata[sj_q[j]]) newrow[j] = 1'b1;
		hit = 1'b0;
		for (int j = 0; j < NSLOT; j++)
			if (5'(j) < n_q && seen_q[j] && fin_q[j]) hit = 1'b1;
	end

	// memory addresses
	always_comb begin
		dm_we    = 1'b0;
		dm_waddr = i_q;
		dm_wdata = row_q;
		dm_raddr = i_q;
		tr_addr  = {jj_q[3:0], k_q[1:0]};
		unique case (st_q)
			ST_INIT: begin
				dm_we = 1'b1;
				dm_wdata = init_row;
			end
			ST_PSYM: begin
				if (ph_q == 2'd3) dm_raddr = si_q;
			end
			ST_PEND: dm_we = 1'b1;
			ST_RSYM: tr_addr = {ri_q[3:0], k_q[1:0]};
			default: ;
		endcase
	end

	logic [4:0] rep;
	always_comb begin
		rep = i_q;
		for (int j = NSLOT-1; j >= 0; j--)
			if (5'(j) < n_q && !row_q[j]) rep = 5'(j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			fin_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q      <= st_d;
			out_valid <= 1'b0;
			if (accept && in_beat.mode == MODE_FINAL)
				fin_q[{1'b0, in_beat.src_state}] <= in_beat.final_flag;
			if (st_q == ST_IDLE && st_d == ST_INIT)
				fin_q[NSLOT-1] <= 1'b0;
			if (st_q == ST_EMIT) out_valid <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				n_q <= (n_clamp > 5'(MAX_STATES)) ? 5'(MAX_STATES) : n_clamp;
				m_q <= m_clamp;
				i_q <= '0;
			end
			ST_INIT: begin
				i_q <= (i_q == n_q) ? 5'd0 : i_q + 5'd1;
				changed_q <= 1'b0;
			end
			ST_PROW: begin
				row_q <= '0;
				k_q <= '0;
				ph_q <= '0;
				jj_q <= '0;
			end
			ST_PSYM: begin
				// ph 0: issue read of trans[jj][k]; ph 2: capture; ph 3: row read
				unique case (ph_q)
					2'd0: ph_q <= 2'd1;
					2'd1: ph_q <= 2'd2;
					2'd2: begin
						sj_q[jj_q] <= (jj_q == n_q) ? n_q : tsucc;
						if (jj_q == i_q) si_q <= (jj_q == n_q) ? n_q : tsucc;
						if (jj_q == n_q) ph_q <= 2'd3;
						else begin
							jj_q <= jj_q + 5'd1;
							ph_q <= 2'd0;
						end
					end
					default: ph_q <= 2'd3;
				endcase
				if (k_q == 3'd0 && ph_q == 2'd0 && jj_q == 5'd0) row_q <= dm_rdata;
			end
			ST_PCHK: begin
				row_q <= newrow;
				if (newrow != row_q) changed_q <= 1'b1;
				k_q <= k_q + 3'd1;
				jj_q <= '0;
				ph_q <= '0;
			end
			ST_PEND: begin
				if (i_q == n_q) begin
					i_q <= '0;
					if (changed_q) changed_q <= 1'b0;
				end else i_q <= i_q + 5'd1;
			end
			ST_OROW: ;
			ST_ORWAIT: begin
				row_q  <= dm_rdata;
				seen_q <= NSLOT'(1) << i_q;
				ri_q <= '0;
				k_q <= '0;
				ph_q <= '0;
				grew_q <= 1'b0;
			end
			ST_RSYM: ph_q <= ph_q + 2'd1;
			ST_RCHK: begin
				if (seen_q[ri_q] && !seen_q[tsucc]) begin
					seen_q[tsucc] <= 1'b1;
					grew_q <= 1'b1;
				end
				k_q <= k_q + 3'd1;
				ph_q <= '0;
			end
			ST_REND: begin
				k_q <= '0;
				ph_q <= '0;
				if (ri_q + 5'd1 >= n_q) begin
					ri_q <= '0;
					grew_q <= 1'b0;
				end else ri_q <= ri_q + 5'd1;
			end
			ST_EMIT: begin
				out_beat.state_index    <= i_q[3:0];
				out_beat.class_rep      <= rep[3:0];
				out_beat.is_accepting   <= fin_q[i_q];
				out_beat.in_start_class <= ({1'b0, start_state_q} < n_q)
					&& !row_q[{1'b0, start_state_q}];
				out_beat.useless        <= !fin_q[i_q] && !hit;
				out_beat.last           <= (i_q + 5'd1 == n_q);
				i_q <= i_q + 5'd1;
			end
			default: ;
		endcase
	end
endmodule
